>>> hw/rtl/round_robin_thread_scheduler_defines.svh
// Assertion macros for the scheduler RTL.
// RRTS_ASSERT checks that a property holds; RRTS_ASSERT_NEVER checks that a condition never holds.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
`define RRTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("scheduler assertion failed");
`define RRTS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("scheduler assertion failed");
`else
`define RRTS_ASSERT(lbl, clk, rstn, prop)
`define RRTS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> hw/rtl/rrts_pkg.sv
package rrts_pkg;

  localparam int unsigned THREAD_SLOTS_DEF = 256;
  localparam int unsigned PTR_W            = 32;
  localparam int unsigned TID_W            = 8;
  localparam int unsigned MODE_W           = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_SWITCH = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_EXIT   = 2'd2,
    MODE_PEEK   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SLOT_UNUSED    = 2'd0,
    SLOT_EXITING   = 2'd1,
    SLOT_SUSPENDED = 2'd2,
    SLOT_ACTIVE    = 2'd3
  } slot_state_e;

endpackage

>>> hw/rtl/rrts_ram.sv
module rrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/round_robin_thread_scheduler.sv
// Round-robin thread-slot scheduler: one result beat per input beat, one item at a time.
// Each slot-table step reads an entry from the slot RAM and writes it back if it changes it;
//   a freed entry is written without a read. Switch and exit save the old stack pointer, then
//   walk the ring, freeing exiting slots; create links the free-list head into the ring.
//   A new beat is taken in the cycle after the output register loads.
// Reset clears control at once, then a pass over every slot writes the slot RAM; tready is low.
`include "round_robin_thread_scheduler_defines.svh"

module round_robin_thread_scheduler #(
  parameter int unsigned THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input beats
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rrts_pkg::PTR_W-1:0]         s_axis_tdata,  // [31:0] stack_pointer
  input  logic [rrts_pkg::MODE_W-1:0]        s_axis_tuser,  // [1:0] mode
  // result beats
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rrts_pkg::PTR_W+rrts_pkg::TID_W-1:0] m_axis_tdata,
                                             // [7:0] thread_id, [39:8] resume_pointer
  output logic                               m_axis_tuser   // [0] status
);

  localparam int unsigned IdW   = $clog2(THREAD_SLOTS);
  localparam int unsigned KW    = $clog2(2 * THREAD_SLOTS + 1);
  localparam int unsigned PtrW  = rrts_pkg::PTR_W;
  localparam int unsigned TidW  = rrts_pkg::TID_W;
  localparam int unsigned WordW = 2 * IdW + PtrW + 2;
  localparam logic [IdW-1:0] LastSlot = IdW'(THREAD_SLOTS - 1);
  localparam logic [KW-1:0]  WalkLim  = KW'(2 * THREAD_SLOTS);

  // Sequencer states, one-hot. Each table step reads an entry in phase 0
  // and, where it changes it, writes it back in phase 1.
  typedef enum logic [16:0] {
    ST_INIT    = 17'h00001,  // clearing pass over the slot RAM
    ST_IDLE    = 17'h00002,
    ST_SAVE    = 17'h00004,  // store old stack pointer, mark exiting on exit
    ST_WALK    = 17'h00008,  // inspect ring slot c
    ST_UNL_N   = 17'h00010,  // prev[n] = p
    ST_UNL_P   = 17'h00020,  // next[p] = n
    ST_FREE_C  = 17'h00040,  // rewrite freed slot as free-list tail
    ST_FREE_T  = 17'h00080,  // next[old tail] = c
    ST_CR_ZERO = 17'h00100,  // pick anchor from slot 0 state
    ST_CR_HEAD = 17'h00200,  // fetch successor of free head
    ST_CR_NEXT = 17'h00400,  // new free head links back to itself
    ST_CR_ANCH = 17'h00800,  // fetch prev of anchor
    ST_CR_SLOT = 17'h01000,  // new slot: links, pointer, active
    ST_CR_BEF  = 17'h02000,  // next[before] = s
    ST_CR_ANC2 = 17'h04000,  // prev[anchor] = s
    ST_PEEK    = 17'h08000,  // read current slot only
    ST_FIN     = 17'h10000   // hand the result to the output register
  } sched_state_e;

  sched_state_e state_q, state_d;
  logic         phase_q, phase_d;
  logic [IdW-1:0] init_cnt_q, init_cnt_d;

  // Scheduler registers
  logic [IdW-1:0] cur_q, cur_d;
  logic [IdW-1:0] free_head_q, free_head_d;
  logic [IdW-1:0] free_tail_q, free_tail_d;
  logic           free_empty_q, free_empty_d;

  // Per-item working registers
  rrts_pkg::mode_e mode_q, mode_d;
  logic [PtrW-1:0] sp_q, sp_d;
  logic [IdW-1:0]  c_q, c_d;
  logic [IdW-1:0]  n_q, n_d;
  logic [IdW-1:0]  p_q, p_d;
  logic [IdW-1:0]  s_q, s_d;
  logic [IdW-1:0]  anchor_q, anchor_d;
  logic [IdW-1:0]  before_q, before_d;
  logic [KW-1:0]   k_q, k_d;

  // Pending result and output register
  logic            res_status_q, res_status_d;
  logic [IdW-1:0]  res_id_q, res_id_d;
  logic [PtrW-1:0] res_ptr_q, res_ptr_d;
  logic            out_valid_q, out_valid_d;
  logic            out_status_q, out_status_d;
  logic [TidW-1:0] out_id_q, out_id_d;
  logic [PtrW-1:0] out_ptr_q, out_ptr_d;

  // Slot RAM: {state, saved pointer, prev, next}
  logic             mem_we;
  logic [IdW-1:0]   mem_addr;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] mem_rdata;

  logic [IdW-1:0]        r_next, r_prev;
  logic [PtrW-1:0]       r_ptr;
  rrts_pkg::slot_state_e r_st;
  logic [IdW-1:0]        w_next, w_prev;
  logic [PtrW-1:0]       w_ptr;
  rrts_pkg::slot_state_e w_st;

  rrts_ram #(
    .WIDTH (WordW),
    .DEPTH (THREAD_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  assign r_next    = mem_rdata[IdW-1:0];
  assign r_prev    = mem_rdata[2*IdW-1:IdW];
  assign r_ptr     = mem_rdata[2*IdW+PtrW-1:2*IdW];
  assign r_st      = rrts_pkg::slot_state_e'(mem_rdata[WordW-1:WordW-2]);
  assign mem_wdata = {w_st, w_ptr, w_prev, w_next};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ptr_q, out_id_q};
  assign m_axis_tuser  = out_status_q;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    init_cnt_d   = init_cnt_q;
    cur_d        = cur_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    free_empty_d = free_empty_q;
    mode_d       = mode_q;
    sp_d         = sp_q;
    c_d          = c_q;
    n_d          = n_q;
    p_d          = p_q;
    s_d          = s_q;
    anchor_d     = anchor_q;
    before_d     = before_q;
    k_d          = k_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_ptr_d    = res_ptr_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_ptr_d    = out_ptr_q;
    out_valid_d  = out_valid_q && !m_axis_tready;

    mem_we   = 1'b0;
    mem_addr = '0;
    w_next   = r_next;
    w_prev   = r_prev;
    w_ptr    = r_ptr;
    w_st     = r_st;

    case (state_q)
      ST_INIT: begin
        // slot 0 alone in the ring, the rest chained in index order
        mem_we   = 1'b1;
        mem_addr = init_cnt_q;
        w_ptr    = '0;
        w_st     = (init_cnt_q == '0) ? rrts_pkg::SLOT_ACTIVE : rrts_pkg::SLOT_UNUSED;
        if (init_cnt_q == '0 || init_cnt_q == LastSlot) begin
          w_next = init_cnt_q;
        end else begin
          w_next = init_cnt_q + IdW'(1);
        end
        if (init_cnt_q > IdW'(1)) begin
          w_prev = init_cnt_q - IdW'(1);
        end else begin
          w_prev = init_cnt_q;
        end
        init_cnt_d = init_cnt_q + IdW'(1);
        if (init_cnt_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        phase_d = 1'b0;
        if (s_axis_tvalid) begin
          mode_d = rrts_pkg::mode_e'(s_axis_tuser);
          sp_d   = s_axis_tdata;
          s_d    = free_head_q;
          case (rrts_pkg::mode_e'(s_axis_tuser))
            rrts_pkg::MODE_SWITCH, rrts_pkg::MODE_EXIT: begin
              state_d = ST_SAVE;
            end
            rrts_pkg::MODE_CREATE: begin
              if (free_empty_q) begin
                res_status_d = 1'b1;
                res_id_d     = '0;
                res_ptr_d    = '0;
                state_d      = ST_FIN;
              end else begin
                state_d = ST_CR_ZERO;
              end
            end
            default: begin
              state_d = ST_PEEK;
            end
          endcase
        end
      end

      ST_SAVE: begin
        mem_addr = cur_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          mem_we = 1'b1;
          w_ptr  = sp_q;
          if (mode_q == rrts_pkg::MODE_EXIT) begin
            w_st = rrts_pkg::SLOT_EXITING;
          end
          c_d     = r_next;
          k_d     = '0;
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        mem_addr = c_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          if (k_q == WalkLim || r_st == rrts_pkg::SLOT_ACTIVE ||
              (r_st == rrts_pkg::SLOT_EXITING && r_next == c_q)) begin
            // stop here: active slot, last exiting slot, or walk bound hit
            cur_d        = c_q;
            res_status_d = 1'b0;
            res_id_d     = c_q;
            res_ptr_d    = r_ptr;
            state_d      = ST_FIN;
          end else if (r_st == rrts_pkg::SLOT_EXITING) begin
            n_d     = r_next;
            p_d     = r_prev;
            state_d = ST_UNL_N;
          end else begin
            // skip suspended and stray unused slots
            c_d = r_next;
            k_d = k_q + KW'(1);
          end
        end
      end

      ST_UNL_N: begin
        mem_addr = n_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          mem_we  = 1'b1;
          w_prev  = p_q;
          state_d = ST_UNL_P;
        end
      end

      ST_UNL_P: begin
        mem_addr = p_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          mem_we  = 1'b1;
          w_next  = n_q;
          state_d = ST_FREE_C;
        end
      end

      ST_FREE_C: begin
        // every field is known, so write without reading
        mem_addr = c_q;
        mem_we   = 1'b1;
        w_st     = rrts_pkg::SLOT_UNUSED;
        w_ptr    = '0;
        w_next   = c_q;
        w_prev   = free_empty_q ? c_q : free_tail_q;
        if (free_empty_q) begin
          free_head_d  = c_q;
          free_tail_d  = c_q;
          free_empty_d = 1'b0;
          c_d          = n_q;
          k_d          = k_q + KW'(1);
          state_d      = ST_WALK;
        end else begin
          state_d = ST_FREE_T;
        end
      end

      ST_FREE_T: begin
        mem_addr = free_tail_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          mem_we      = 1'b1;
          w_next      = c_q;
          free_tail_d = c_q;
          c_d         = n_q;
          k_d         = k_q + KW'(1);
          state_d     = ST_WALK;
        end
      end

      ST_CR_ZERO: begin
        mem_addr = '0;
        phase_d  = !phase_q;
        if (phase_q) begin
          anchor_d = (r_st == rrts_pkg::SLOT_UNUSED) ? cur_q : '0;
          if (s_q == free_tail_q) begin
            free_empty_d = 1'b1;
            state_d      = ST_CR_ANCH;
          end else begin
            state_d = ST_CR_HEAD;
          end
        end
      end

      ST_CR_HEAD: begin
        mem_addr = s_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          n_d         = r_next;
          free_head_d = r_next;
          state_d     = ST_CR_NEXT;
        end
      end

      ST_CR_NEXT: begin
        mem_addr = n_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          mem_we  = 1'b1;
          w_prev  = n_q;
          state_d = ST_CR_ANCH;
        end
      end

      ST_CR_ANCH: begin
        mem_addr = anchor_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          before_d = r_prev;
          state_d  = ST_CR_SLOT;
        end
      end

      ST_CR_SLOT: begin
        mem_addr = s_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          mem_we  = 1'b1;
          w_prev  = before_q;
          w_next  = anchor_q;
          w_ptr   = sp_q;
          w_st    = rrts_pkg::SLOT_ACTIVE;
          state_d = ST_CR_BEF;
        end
      end

      ST_CR_BEF: begin
        mem_addr = before_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          mem_we  = 1'b1;
          w_next  = s_q;
          state_d = ST_CR_ANC2;
        end
      end

      ST_CR_ANC2: begin
        mem_addr = anchor_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          mem_we       = 1'b1;
          w_prev       = s_q;
          res_status_d = 1'b0;
          res_id_d     = s_q;
          res_ptr_d    = '0;
          state_d      = ST_FIN;
        end
      end

      ST_PEEK: begin
        mem_addr = cur_q;
        phase_d  = !phase_q;
        if (phase_q) begin
          res_status_d = 1'b0;
          res_id_d     = cur_q;
          res_ptr_d    = r_ptr;
          state_d      = ST_FIN;
        end
      end

      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = TidW'(res_id_q);
          out_ptr_d    = res_ptr_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      phase_q      <= 1'b0;
      init_cnt_q   <= '0;
      cur_q        <= '0;
      free_head_q  <= IdW'(1);
      free_tail_q  <= LastSlot;
      free_empty_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      init_cnt_q   <= init_cnt_d;
      cur_q        <= cur_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      free_empty_q <= free_empty_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    sp_q         <= sp_d;
    c_q          <= c_d;
    n_q          <= n_d;
    p_q          <= p_d;
    s_q          <= s_d;
    anchor_q     <= anchor_d;
    before_q     <= before_d;
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_ptr_q    <= res_ptr_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_ptr_q    <= out_ptr_d;
  end

  // An empty free list always leaves head and tail on the same slot.
  `RRTS_ASSERT(a_free_empty_head_tail, clk_i, rst_ni, free_empty_q |-> (free_head_q == free_tail_q))
  // The walk never runs past its bound.
  `RRTS_ASSERT(a_walk_bound, clk_i, rst_ni, (state_q == ST_WALK) |-> (k_q <= WalkLim))
  // A result beat only appears after the sequencer handed it over.
  `RRTS_ASSERT(a_out_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_FIN))
  // The current slot stays inside the table.
  `RRTS_ASSERT_NEVER(a_cur_range, clk_i, rst_ni, cur_q > LastSlot)

endmodule

>>> sim/round_robin_thread_scheduler_tb.sv
`timescale 1ns / 1ps

module round_robin_thread_scheduler_tb;
  import rrts_pkg::*;

  localparam int unsigned SLOTS        = THREAD_SLOTS_DEF;
  localparam int unsigned IDLE_PCT     = 18;
  // Worst switch frees all but one slot in one walk, plus the clearing pass
  // after reset; take that several times over.
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned DIRECTED_LEN = 20;

  typedef logic [TID_W-1:0] slot_t;

  typedef struct packed {
    logic             status;
    slot_t            thread_id;
    logic [PTR_W-1:0] resume_ptr;
  } sched_result_t;

  // One row of the directed table; fixed marks a result typed in by hand.
  typedef struct packed {
    mode_e            mode;
    logic [PTR_W-1:0] sp;
    bit               fixed;
    sched_result_t    result;
  } stim_row_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [PTR_W-1:0]         s_axis_tdata  = '0;  // [31:0] stack_pointer
  logic [MODE_W-1:0]        s_axis_tuser  = '0;  // [1:0] mode
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [PTR_W+TID_W-1:0]   m_axis_tdata;        // [7:0] thread_id, [39:8] resume_pointer
  logic                     m_axis_tuser;        // [0] status

  // Shadow copy of the slot table.
  slot_t            link_next [SLOTS];
  slot_t            link_prev [SLOTS];
  logic [PTR_W-1:0] slot_sp   [SLOTS];
  slot_state_e      slot_st   [SLOTS];
  slot_t            cur_slot;
  slot_t            free_first;
  slot_t            free_last;
  bit               free_none;

  sched_result_t    pending_results [$];
  int               errors      = 0;
  int unsigned      idle_cycles = 0;
  bit               steady      = 1'b0;

  stim_row_t directed_rows [DIRECTED_LEN] = '{
    // right after reset: slot 0 alone and current
    '{MODE_PEEK,   32'h0000_0000, 1'b1, '{1'b0, 8'd0, 32'h0000_0000}},
    '{MODE_SWITCH, 32'hFFFF_FFFF, 1'b1, '{1'b0, 8'd0, 32'hFFFF_FFFF}},
    '{MODE_SWITCH, 32'h0000_0000, 1'b1, '{1'b0, 8'd0, 32'h0000_0000}},
    // lone exiting slot stays current
    '{MODE_EXIT,   32'hA5A5_A5A5, 1'b1, '{1'b0, 8'd0, 32'hA5A5_A5A5}},
    // free list head is slot 1
    '{MODE_CREATE, 32'h1234_5678, 1'b1, '{1'b0, 8'd1, 32'h0000_0000}},
    '{MODE_SWITCH, 32'h5A5A_5A5A, 1'b0, '0},
    // walk passes exiting slot 0 and frees it
    '{MODE_SWITCH, 32'h0000_0001, 1'b0, '0},
    // slot 0 unused: anchor new slot on the current one
    '{MODE_CREATE, 32'h89AB_CDEF, 1'b0, '0},
    '{MODE_CREATE, 32'h8000_0000, 1'b0, '0},
    '{MODE_PEEK,   32'h0000_0000, 1'b0, '0},
    '{MODE_SWITCH, 32'h7FFF_FFFF, 1'b0, '0},
    '{MODE_EXIT,   32'h0000_FFFF, 1'b0, '0},
    '{MODE_EXIT,   32'hFFFF_0000, 1'b0, '0},
    '{MODE_SWITCH, 32'h3333_3333, 1'b0, '0},
    '{MODE_PEEK,   32'hC3C3_C3C3, 1'b0, '0},
    '{MODE_CREATE, 32'h0000_0000, 1'b0, '0},
    '{MODE_CREATE, 32'hFFFF_FFFF, 1'b0, '0},
    '{MODE_EXIT,   32'h0F0F_0F0F, 1'b0, '0},
    '{MODE_SWITCH, 32'hF0F0_F0F0, 1'b0, '0},
    '{MODE_PEEK,   32'h0000_0000, 1'b0, '0}
  };

  round_robin_thread_scheduler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Save the old stack pointer, then walk the ring from the next slot: free
  // exiting slots, skip the rest, stop on the first active one.
  function automatic sched_result_t switch_thread(logic [PTR_W-1:0] sp);
    sched_result_t r;
    slot_t         c;
    slot_t         n;
    slot_t         p;
    slot_sp[cur_slot] = sp;
    c = link_next[cur_slot];
    for (int k = 0; k < 2 * SLOTS; k++) begin
      if (slot_st[c] == SLOT_ACTIVE) break;
      if (slot_st[c] == SLOT_EXITING) begin
        n = link_next[c];
        p = link_prev[c];
        // a lone exiting slot is kept and becomes current
        if (n == c) break;
        link_prev[n] = p;
        link_next[p] = n;
        slot_sp[c] = '0;
        slot_st[c] = SLOT_UNUSED;
        // append to the tail of the free chain
        if (free_none) begin
          free_first = c;
          free_last  = c;
          link_prev[c] = c;
          free_none  = 1'b0;
        end else begin
          link_next[free_last] = c;
          link_prev[c] = free_last;
          free_last = c;
        end
        link_next[c] = c;
        c = n;
      end else begin
        c = link_next[c];
      end
    end
    cur_slot = c;
    r = '0;
    r.thread_id  = c;
    r.resume_ptr = slot_sp[c];
    return r;
  endfunction

  // Advance the shadow table by one input beat and return the result it causes.
  function automatic sched_result_t predict_schedule(mode_e mode, logic [PTR_W-1:0] sp);
    sched_result_t r;
    slot_t         s;
    slot_t         anchor;
    slot_t         ahead;
    r = '0;
    case (mode)
      MODE_SWITCH: begin
        r = switch_thread(sp);
      end
      MODE_EXIT: begin
        slot_st[cur_slot] = SLOT_EXITING;
        r = switch_thread(sp);
      end
      MODE_CREATE: begin
        if (free_none) begin
          r.status = 1'b1;
        end else begin
          s = free_first;
          anchor = (slot_st[0] == SLOT_UNUSED) ? cur_slot : slot_t'(0);
          if (s == free_last) begin
            free_none = 1'b1;
          end else begin
            free_first = link_next[s];
            link_prev[free_first] = free_first;
          end
          // link in just before the anchor
          ahead = link_prev[anchor];
          link_prev[s]      = ahead;
          link_next[s]      = anchor;
          link_next[ahead]  = s;
          link_prev[anchor] = s;
          slot_sp[s] = sp;
          slot_st[s] = SLOT_ACTIVE;
          r.thread_id = s;
        end
      end
      default: begin
        r.thread_id  = cur_slot;
        r.resume_ptr = slot_sp[cur_slot];
      end
    endcase
    return r;
  endfunction

  // Drive one input beat, hold it until accepted, then maybe leave a gap.
  task automatic send_beat(mode_e mode, logic [PTR_W-1:0] sp, bit fixed,
                           sched_result_t fixed_result);
    sched_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= sp;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_schedule(mode, sp);
    pending_results.push_back(fixed ? fixed_result : r);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random beats with the given mode mix (percent); the rest are switches.
  // The first calm_beats run with no idling on either side.
  task automatic run_phase(int beats, int pct_create, int pct_exit, int pct_peek,
                           int calm_beats);
    int    roll;
    mode_e mode;
    for (int i = 0; i < beats; i++) begin
      steady <= (i < calm_beats);
      roll = $urandom_range(99);
      if (roll < pct_create) mode = MODE_CREATE;
      else if (roll < pct_create + pct_exit) mode = MODE_EXIT;
      else if (roll < pct_create + pct_exit + pct_peek) mode = MODE_PEEK;
      else mode = MODE_SWITCH;
      send_beat(mode, $urandom, 1'b0, '0);
    end
    steady <= 1'b0;
  endtask

  // Result side: stall at random unless in a steady stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result beat with the oldest expectation; watch for a hang.
  always @(posedge clk_i) begin : result_check
    sched_result_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        errors = errors + 1;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          errors = errors + 1;
        end
        if (m_axis_tdata[TID_W-1:0] !== want.thread_id) begin
          $error("thread_id: expected %0d, got %0d", want.thread_id,
                 m_axis_tdata[TID_W-1:0]);
          errors = errors + 1;
        end
        if (m_axis_tdata[TID_W +: PTR_W] !== want.resume_ptr) begin
          $error("resume_pointer: expected %h, got %h", want.resume_ptr,
                 m_axis_tdata[TID_W +: PTR_W]);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    // Load the shadow table with the reset state: slot 0 alone in the ring,
    // every other slot chained on the free list in index order.
    for (int i = 0; i < SLOTS; i++) begin
      slot_sp[i]   = '0;
      slot_st[i]   = SLOT_UNUSED;
      link_next[i] = slot_t'((i + 1 < SLOTS) ? i + 1 : i);
      link_prev[i] = slot_t'((i > 1) ? i - 1 : i);
    end
    link_next[0] = '0;
    link_prev[0] = '0;
    slot_st[0]   = SLOT_ACTIVE;
    cur_slot     = '0;
    free_first   = slot_t'(1);
    free_last    = slot_t'(SLOTS - 1);
    free_none    = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: reset state, lone exit, freeing slot 0, anchor moves.
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      send_beat(directed_rows[i].mode, directed_rows[i].sp, directed_rows[i].fixed,
                directed_rows[i].result);
    end

    // Fill the table with creates until the free list runs dry and creates fail.
    run_phase(330, 85, 0, 3, 0);
    // Hold off the sender once until the pipeline is empty.
    wait_results_drained();
    // Thin out the ring with mostly exits.
    run_phase(240, 8, 62, 5, 0);
    // Mixed traffic, opening with a long stretch with no idling.
    run_phase(130, 35, 30, 10, 60);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ram.sv
hw/rtl/round_robin_thread_scheduler.sv
sim/round_robin_thread_scheduler_tb.sv
